>>> rtl/self_organizing_list_transpose_top_assert.svh
// ----------------------------------------------------------------------------
// self_organizing_list_transpose_top_assert.svh
// assertion macros for the self-organizing list block
// ----------------------------------------------------------------------------
`ifndef SELF_ORGANIZING_LIST_TRANSPOSE_TOP_ASSERT_SVH
`define SELF_ORGANIZING_LIST_TRANSPOSE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define SOLT_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// same-cycle implication
`define SOLT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SOLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SOLT_ASSERT_ALWAYS(lbl, cond)
`define SOLT_ASSERT_IMPL(lbl, ante, cons)
`define SOLT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/solt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// solt_pkg
// shared types and codes of the self-organizing list block
// ----------------------------------------------------------------------------
package solt_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_SEARCH = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_FOUND  = 2'd1,
    STAT_MISS   = 2'd2,
    STAT_REJECT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_SWAP = 4'b0100,
    ST_READ = 4'b1000
  } state_t;

  // finished result handed from the controller to the output register
  typedef struct packed {
    logic               load;
    status_t            status;
    logic signed [31:0] read_value;
    logic [4:0]         list_length;
  } res_t;

endpackage

>>> rtl/solt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// solt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module solt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/solt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// solt_ctrl
// sequencer that scans, swaps and reads the entry ram, and keeps the length
// ----------------------------------------------------------------------------
module solt_ctrl #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [1:0]                        operation,
  input  logic signed [31:0]                value,
  input  logic [3:0]                        position,
  input  logic                              out_free,
  output solt_pkg::res_t                    res,
  output logic [$clog2(LIST_DEPTH+1)-1:0]   length
);

  import solt_pkg::*;

  localparam int AW = $clog2(LIST_DEPTH);
  localparam int LW = $clog2(LIST_DEPTH + 1);

  state_t          state, state_next;
  logic [AW-1:0]   idx, idx_next;
  logic [31:0]     prev, prev_next;
  logic [31:0]     key, key_next;
  logic [LW-1:0]   length_next;
  logic [31:0]     len_wide;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [31:0]     ram_wdata, ram_rdata;

  logic            accept, hit, last;

  solt_ram #(
    .WIDTH (32),
    .DEPTH (LIST_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req_stall = (state != ST_IDLE) || !out_free;
  assign accept    = req_valid && !req_stall;
  assign hit       = (ram_rdata == key);
  assign last      = ((LW'(idx) + LW'(1)) == length);

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    prev_next   = prev;
    key_next    = key;
    length_next = length;
    ram_we      = 1'b0;
    ram_waddr   = idx;
    ram_wdata   = key;
    ram_re      = 1'b0;
    ram_raddr   = idx;
    res.load       = 1'b0;
    res.status     = STAT_DONE;
    res.read_value = '0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (operation)
            OP_APPEND: begin
              res.load = 1'b1;
              if (length == LW'(LIST_DEPTH)) begin
                res.status = STAT_REJECT;
              end else begin
                ram_we      = 1'b1;
                ram_waddr   = AW'(length);
                ram_wdata   = value;
                length_next = length + LW'(1);
              end
            end
            OP_SEARCH: begin
              if (length == '0) begin
                res.load   = 1'b1;
                res.status = STAT_MISS;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                idx_next   = '0;
                key_next   = value;
                state_next = ST_SCAN;
              end
            end
            OP_READ: begin
              if (32'(position) < 32'(length)) begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(position);
                state_next = ST_READ;
              end else begin
                res.load   = 1'b1;
                res.status = STAT_REJECT;
              end
            end
            default: begin
              res.load   = 1'b1;
              res.status = STAT_REJECT;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // ram_rdata holds entry idx; prev holds entry idx-1
        if (hit) begin
          if (idx == '0) begin
            if (out_free) begin
              res.load   = 1'b1;
              res.status = STAT_FOUND;
              state_next = ST_IDLE;
            end
          end else begin
            ram_we     = 1'b1;
            ram_waddr  = idx - AW'(1);
            ram_wdata  = key;
            state_next = ST_SWAP;
          end
        end else if (last) begin
          if (out_free) begin
            res.load   = 1'b1;
            res.status = STAT_MISS;
            state_next = ST_IDLE;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx + AW'(1);
          idx_next  = idx + AW'(1);
          prev_next = ram_rdata;
        end
      end
      ST_SWAP: begin
        // second half of the transpose, rewriting is harmless while held
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = prev;
        if (out_free) begin
          res.load   = 1'b1;
          res.status = STAT_FOUND;
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free) begin
          res.load       = 1'b1;
          res.status     = STAT_DONE;
          res.read_value = $signed(ram_rdata);
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    len_wide        = 32'(length_next);
    res.list_length = len_wide[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      length <= '0;
    end else begin
      state  <= state_next;
      length <= length_next;
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    prev <= prev_next;
    key  <= key_next;
  end

endmodule

>>> rtl/solt_oreg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// solt_oreg
// output register holding one finished result until its transaction completes
// ----------------------------------------------------------------------------
module solt_oreg (
  input  logic               clk,
  input  logic               rst,
  input  solt_pkg::res_t     res,
  output logic               out_free,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [1:0]         status,
  output logic signed [31:0] read_value,
  output logic [4:0]         list_length
);

  import solt_pkg::*;

  res_t held;

  assign out_free    = !rsp_valid || !rsp_stall;
  assign status      = held.status;
  assign read_value  = held.read_value;
  assign list_length = held.list_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res.load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      held <= res;
    end
  end

endmodule

>>> rtl/self_organizing_list_transpose_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// self_organizing_list_transpose_top
// array-based self-organizing list with the transpose heuristic
// ----------------------------------------------------------------------------
// The block works on one transaction at a time and gives exactly one result
// per transaction. An append, a rejected read and an unknown operation
// produce their result in the accept cycle. A read waits for the registered
// read data of the entry ram; a search scans the stored entries from the front
// to a match or the last entry and swaps a match away from the front forward.
// The search time is set by the single read port of the entry ram, which the
// scan walks one entry per cycle. A finished result waits in the output
// register, and no new transaction is taken while it is stalled there; it is
// taken in the cycle the waiting result leaves. The entry ram needs no
// clearing after reset, since only positions below the length are ever read.
module self_organizing_list_transpose_top #(
  parameter int LIST_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         operation,
  input  logic signed [31:0] value,
  input  logic [3:0]         position,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [1:0]         status,
  output logic signed [31:0] read_value,
  output logic [4:0]         list_length
);

  import solt_pkg::*;

  `include "self_organizing_list_transpose_top_assert.svh"

  localparam int LW = $clog2(LIST_DEPTH + 1);

  res_t          res;
  logic          out_free;
  logic [LW-1:0] length;
  logic          append_room;

  solt_ctrl #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .operation (operation),
    .value     (value),
    .position  (position),
    .out_free  (out_free),
    .res       (res),
    .length    (length)
  );

  solt_oreg u_oreg (
    .clk         (clk),
    .rst         (rst),
    .res         (res),
    .out_free    (out_free),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .read_value  (read_value),
    .list_length (list_length)
  );

  // accepted append with a free slot
  assign append_room = req_valid && !req_stall && (operation == OP_APPEND) &&
                       (length < LW'(LIST_DEPTH));

  `SOLT_ASSERT_ALWAYS(a_length_bound, length <= LW'(LIST_DEPTH))
  `SOLT_ASSERT_IMPL(a_no_overwrite, res.load, !(rsp_valid && rsp_stall))
  `SOLT_ASSERT_NEXT(a_append_grows, append_room, length == $past(length) + LW'(1))
  `SOLT_ASSERT_IMPL(a_zero_unless_read, rsp_valid && status != STAT_DONE, read_value == '0)

endmodule

>>> dv/tb_self_organizing_list_transpose_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_self_organizing_list_transpose_top
// self-checking bench for the transpose-heuristic self-organizing list
// ----------------------------------------------------------------------------
// A directed sequence walks the empty, one-entry, partly filled and full list.
// It covers a head match, a swap forward, a duplicate value, reads at and past
// the length, an append when full and the unused operation code. A random mix
// of searches, reads, appends and unused codes follows. Most searches look
// for values already stored, so entries keep moving forward. A scoreboard
// class keeps its own copy of the list, predicts each result when the request
// transaction is accepted and checks every response field by field. Both
// sides idle at random, apart from one long stretch without idling.
// ----------------------------------------------------------------------------
module tb_self_organizing_list_transpose_top;
  import solt_pkg::*;

  localparam int DEPTH        = 16;
  localparam int QUIET_ITEMS  = 300;
  localparam int BUSY_ITEMS   = 1600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    status_t            status;
    logic signed [31:0] read_value;
    logic [4:0]         list_length;
  } list_result_t;

  class list_scoreboard;
    logic signed [31:0] stored [DEPTH];
    int unsigned        count;
    int unsigned        errors;
    list_result_t       awaited [$];

    function new();
      count  = 0;
      errors = 0;
      foreach (stored[i]) stored[i] = '0;
    endfunction

    // update the list copy and queue the response this request must produce
    function void note_request(logic [1:0] op, logic signed [31:0] val,
                               logic [3:0] pos);
      list_result_t       r;
      logic signed [31:0] t;
      int                 hit;
      r.status     = STAT_REJECT;
      r.read_value = '0;
      hit          = -1;
      case (op)
        OP_APPEND: begin
          if (count < DEPTH) begin
            stored[count] = val;
            count++;
            r.status = STAT_DONE;
          end
        end
        OP_SEARCH: begin
          r.status = STAT_MISS;
          for (int i = 0; i < count; i++) begin
            if (hit < 0 && stored[i] == val) hit = i;
          end
          if (hit >= 0) begin
            r.status = STAT_FOUND;
            // transpose: a match away from the front moves up by one
            if (hit > 0) begin
              t               = stored[hit - 1];
              stored[hit - 1] = stored[hit];
              stored[hit]     = t;
            end
          end
        end
        OP_READ: begin
          if (pos < count) begin
            r.status     = STAT_DONE;
            r.read_value = stored[pos];
          end
        end
        default: ;
      endcase
      r.list_length = 5'(count);
      awaited.push_back(r);
    endfunction

    function void check_response(logic [1:0] st, logic signed [31:0] rv,
                                 logic [4:0] len);
      list_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t unexpected response: expected none, actual status %0d value %0d length %0d",
                 $time, st, rv, len);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (st !== e.status) begin
        $display("%0t status mismatch: expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (rv !== e.read_value) begin
        $display("%0t read_value mismatch: expected %0d actual %0d", $time,
                 e.read_value, rv);
        errors++;
      end
      if (len !== e.list_length) begin
        $display("%0t list_length mismatch: expected %0d actual %0d", $time,
                 e.list_length, len);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function logic signed [31:0] pick_stored();
      if (count == 0) return $urandom;
      return stored[$urandom_range(count - 1)];
    endfunction
  endclass

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               req_valid   = 1'b0;
  logic [1:0]         operation   = '0;
  logic signed [31:0] value       = '0;
  logic [3:0]         position    = '0;
  logic               rsp_stall   = 1'b0;
  logic               req_idle_on = 1'b1;
  logic               rsp_idle_on = 1'b1;
  int unsigned        cycles      = 0;
  wire                req_stall;
  wire                rsp_valid;
  wire [1:0]          status;
  wire signed [31:0]  read_value;
  wire [4:0]          list_length;

  list_scoreboard sb = new();

  self_organizing_list_transpose_top #(
    .LIST_DEPTH(DEPTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .operation  (operation),
    .value      (value),
    .position   (position),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .read_value (read_value),
    .list_length(list_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // inputs only move at the rising edge, so the falling edge sees what the
  // next rising edge will accept
  always @(negedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(operation, value, position);
      if (rsp_valid && !rsp_stall) sb.check_response(status, read_value, list_length);
    end
  end

  always @(posedge clk) begin
    rsp_stall <= rsp_idle_on && ($urandom_range(99) < 27);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[self_organizing_list_transpose_top] ERROR");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] op, logic signed [31:0] val, logic [3:0] pos);
    while (req_idle_on && $urandom_range(99) < 27) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    value     <= val;
    position  <= pos;
    @(negedge clk);
    while (req_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55)
      send_item(OP_SEARCH, sb.pick_stored(), 4'($urandom_range(15)));
    else if (pick < 67)
      send_item(OP_SEARCH, $urandom, 4'($urandom_range(15)));
    else if (pick < 87)
      send_item(OP_READ, $urandom, 4'($urandom_range(15)));
    else if (pick < 94)
      send_item(OP_APPEND, $urandom, 4'($urandom_range(15)));
    else
      send_item(OP_UNUSED, $urandom, 4'($urandom_range(15)));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty list
    send_item(OP_READ, 32'sd0, 4'd0);
    send_item(OP_SEARCH, 32'sd5, 4'd0);
    send_item(OP_UNUSED, '1, '1);
    // one entry: head match and miss
    send_item(OP_APPEND, 32'sh8000_0000, 4'd0);
    send_item(OP_SEARCH, 32'sh8000_0000, 4'd0);
    send_item(OP_SEARCH, 32'sd1, 4'd0);
    send_item(OP_APPEND, 32'sh7fff_ffff, 4'd0);
    send_item(OP_APPEND, -32'sd1, 4'd0);
    send_item(OP_APPEND, 32'sd0, 4'hf);
    // match at position 1 swaps to the front
    send_item(OP_SEARCH, 32'sh7fff_ffff, 4'd0);
    send_item(OP_READ, 32'sd0, 4'd0);
    send_item(OP_READ, 32'sd0, 4'd4);
    send_item(OP_READ, 32'sd0, 4'hf);
    // small values give duplicates, so first-match order matters
    for (int i = 4; i < DEPTH; i++) send_item(OP_APPEND, $urandom_range(3), 4'(i));
    send_item(OP_SEARCH, 32'sd0, 4'd0);
    send_item(OP_APPEND, 32'sd7, 4'd0);
    send_item(OP_SEARCH, sb.stored[DEPTH-1], 4'd0);
    send_item(OP_READ, 32'sd0, 4'hf);

    req_idle_on = 1'b0;
    rsp_idle_on = 1'b0;
    repeat (QUIET_ITEMS) random_item();
    req_idle_on = 1'b1;
    rsp_idle_on = 1'b1;
    repeat (BUSY_ITEMS) random_item();

    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[self_organizing_list_transpose_top] OK");
    end else begin
      $display("[self_organizing_list_transpose_top] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/solt_pkg.sv
rtl/solt_ram.sv
rtl/solt_ctrl.sv
rtl/solt_oreg.sv
rtl/self_organizing_list_transpose_top.sv
dv/tb_self_organizing_list_transpose_top.sv
